/* hw/rtl/c2rp_pkg.sv */
// c2rp_pkg: shared constants and types for the cartesian to radar polar converter.
// Holds the CORDIC angle table, gain constant, angle limits and register indexes.
// No dependencies.
package c2rp_pkg;

  localparam int ID_W       = 32;
  localparam int RANGE_W    = 25;
  localparam int AZ_W       = 16;
  localparam int EL_W       = 15;
  localparam int Z_W        = 28;  // angle accumulator, degrees Q16
  localparam int GUARD_BITS = 8;
  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 2;

  // 1/K scaled by 2^24
  localparam logic [GAIN_W-1:0] INV_GAIN = 24'd10188014;

  localparam logic signed [Z_W-1:0] Z_HALF_TURN = 28'sd11796480;  // 180 deg
  localparam logic signed [Z_W-1:0] ANGLE_ROUND = 28'sd256;       // half of Q16->Q7 step

  localparam logic signed [AZ_W-1:0] AZ_LIMIT = 16'sd23040;
  localparam logic signed [EL_W-1:0] EL_LIMIT = 15'sd11520;

  // atan(2^-i) in degrees, Q16
  localparam logic signed [Z_W-1:0] ATAN_DEG_Q16 [32] = '{
    28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945,
    28'sd234379,  28'sd117304,  28'sd58666,  28'sd29335,
    28'sd14668,   28'sd7334,    28'sd3667,   28'sd1833,
    28'sd917,     28'sd458,     28'sd229,    28'sd115,
    28'sd57,      28'sd29,      28'sd14,     28'sd7,
    28'sd4,       28'sd2,       28'sd1,      28'sd0,
    28'sd0,       28'sd0,       28'sd0,      28'sd0,
    28'sd0,       28'sd0,       28'sd0,      28'sd0
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_X = 2'd0,
    CFG_SENSOR_Y = 2'd1,
    CFG_SENSOR_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic hz_zero;   // dx and dy both zero
    logic all_zero;  // dx, dy and dz all zero
  } c2rp_flags_t;

endpackage

/* hw/rtl/c2rp_cell.sv */
// c2rp_cell: one registered CORDIC vectoring micro-rotation.
// Depends on c2rp_pkg (angle table, accumulator width).
module c2rp_cell #(
  parameter int W     = 35,
  parameter int SHIFT = 0,
  parameter int SBW   = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [W-1:0]              in_x,
  input  logic signed [W-1:0]              in_y,
  input  logic signed [c2rp_pkg::Z_W-1:0]  in_z,
  input  logic [SBW-1:0]                   in_sb,
  output logic                             out_valid,
  output logic signed [W-1:0]              out_x,
  output logic signed [W-1:0]              out_y,
  output logic signed [c2rp_pkg::Z_W-1:0]  out_z,
  output logic [SBW-1:0]                   out_sb
);

  localparam logic signed [c2rp_pkg::Z_W-1:0] ANGLE = c2rp_pkg::ATAN_DEG_Q16[SHIFT];

  logic                            valid_r;
  logic signed [W-1:0]             x_r, y_r, x_nxt, y_nxt;
  logic signed [c2rp_pkg::Z_W-1:0] z_r, z_nxt;
  logic [SBW-1:0]                  sb_r;
  logic signed [W-1:0]             xs, ys;

  always_comb begin
    xs = in_x >>> SHIFT;
    ys = in_y >>> SHIFT;
    if (!in_y[W-1]) begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + ANGLE;
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      sb_r <= in_sb;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_sb    = sb_r;

endmodule

/* hw/rtl/c2rp_chain.sv */
// c2rp_chain: a full CORDIC vectoring pass, one c2rp_cell per iteration.
// Depends on c2rp_pkg and c2rp_cell.
module c2rp_chain #(
  parameter int N   = 20,
  parameter int W   = 35,
  parameter int SBW = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [W-1:0]              in_x,
  input  logic signed [W-1:0]              in_y,
  input  logic signed [c2rp_pkg::Z_W-1:0]  in_z,
  input  logic [SBW-1:0]                   in_sb,
  output logic                             out_valid,
  output logic signed [W-1:0]              out_x,
  output logic signed [c2rp_pkg::Z_W-1:0]  out_z,
  output logic [SBW-1:0]                   out_sb
);

  logic                            v_c  [0:N];
  logic signed [W-1:0]             x_c  [0:N];
  logic signed [W-1:0]             y_c  [0:N];
  logic signed [c2rp_pkg::Z_W-1:0] z_c  [0:N];
  logic [SBW-1:0]                  sb_c [0:N];

  assign v_c[0]  = in_valid;
  assign x_c[0]  = in_x;
  assign y_c[0]  = in_y;
  assign z_c[0]  = in_z;
  assign sb_c[0] = in_sb;

  for (genvar i = 0; i < N; i++) begin : g_cell
    c2rp_cell #(
      .W     (W),
      .SHIFT (i),
      .SBW   (SBW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (v_c[i]),
      .in_x      (x_c[i]),
      .in_y      (y_c[i]),
      .in_z      (z_c[i]),
      .in_sb     (sb_c[i]),
      .out_valid (v_c[i+1]),
      .out_x     (x_c[i+1]),
      .out_y     (y_c[i+1]),
      .out_z     (z_c[i+1]),
      .out_sb    (sb_c[i+1])
    );
  end

  assign out_valid = v_c[N];
  assign out_x     = x_c[N];
  assign out_z     = z_c[N];
  assign out_sb    = sb_c[N];

endmodule

/* hw/rtl/c2rp_scale.sv */
// c2rp_scale: two-stage CORDIC gain correction, round(mag * INV_GAIN / 2^SH), saturated.
// Depends on c2rp_pkg (INV_GAIN).
module c2rp_scale #(
  parameter int W     = 35,
  parameter int SH    = 24,
  parameter int OUT_W = 34
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  in_mag,
  output logic [OUT_W-1:0]     out_val
);

  localparam int HI_W  = W - 17 + c2rp_pkg::GAIN_W;
  localparam int LO_W  = 16 + c2rp_pkg::GAIN_W + 2;
  localparam int SUM_W = HI_W + 1;
  localparam int RES_W = SUM_W - (SH - 16);

  logic [W-2:0]       mag_pos;
  logic [HI_W-1:0]    hi_r, hi_nxt;
  logic [LO_W-1:0]    lo_r, lo_nxt;
  logic [SUM_W-1:0]   sum;
  logic [RES_W-1:0]   res;
  logic [OUT_W-1:0]   val_r, val_nxt;

  // stage 1: split into a high and a low partial product
  always_comb begin
    mag_pos = in_mag[W-1] ? '0 : in_mag[W-2:0];
    hi_nxt  = HI_W'(mag_pos[W-2:16]) * HI_W'(c2rp_pkg::INV_GAIN);
    lo_nxt  = LO_W'(mag_pos[15:0]) * LO_W'(c2rp_pkg::INV_GAIN)
            + (LO_W'(1) << (SH - 1));
  end

  // stage 2: recombine, shift, saturate
  always_comb begin
    sum = SUM_W'(hi_r) + SUM_W'(lo_r >> 16);
    res = sum[SUM_W-1:SH-16];
  end

  if (RES_W > OUT_W) begin : g_sat
    assign val_nxt = (|res[RES_W-1:OUT_W]) ? '1 : res[OUT_W-1:0];
  end else begin : g_ext
    assign val_nxt = OUT_W'(res);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
      val_r <= val_nxt;
    end
  end

  assign out_val = val_r;

endmodule

/* hw/rtl/cartesian_to_radar_polar.sv */
// cartesian_to_radar_polar: top level of the cartesian to range/azimuth/elevation converter.
// Depends on c2rp_pkg, c2rp_chain (with c2rp_cell) and c2rp_scale.
//
// Takes one target beat per clock: id plus x, y, z in signed metres Q8, and returns
// one beat per target with the id, the slant range (metres Q8, saturating at 2^25-1),
// the azimuth atan2(dy,dx) and the negated elevation, both in degrees Q7, after the
// configured sensor position has been subtracted with saturation. The datapath is a
// fully pipelined row of CORDIC cells: one register stage for the offset, a chain of
// CORDIC_STAGES cells for the azimuth pass, two stages of gain correction, a second
// chain of CORDIC_STAGES cells for the elevation pass, one stage of gain correction
// and angle rounding, and the output register. Throughput is one beat per clock while no
// stall is held. The pipeline moves as a whole: a stall held on a waiting output beat
// freezes every stage and is passed to the input as in_stall in the same cycle. Sensor
// registers are written through the cfg_ port and must only be changed while no beat
// is in flight.
module cartesian_to_radar_polar #(
  parameter int CORDIC_STAGES = 20,
  parameter int POS_WIDTH     = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [c2rp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [POS_WIDTH-1:0]                cfg_wdata,
  // target beats in
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [c2rp_pkg::ID_W-1:0]           in_target_id,
  input  logic signed [POS_WIDTH-1:0]         in_target_x,
  input  logic signed [POS_WIDTH-1:0]         in_target_y,
  input  logic signed [POS_WIDTH-1:0]         in_target_z,
  // polar beats out
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [c2rp_pkg::ID_W-1:0]           out_echo_id,
  output logic [c2rp_pkg::RANGE_W-1:0]        out_range_dist,
  output logic signed [c2rp_pkg::AZ_W-1:0]    out_azimuth_deg,
  output logic signed [c2rp_pkg::EL_W-1:0]    out_elevation_deg
);

  localparam int P      = POS_WIDTH;
  localparam int W      = POS_WIDTH + 11;  // CORDIC x/y, headroom for gain and sqrt(3)
  localparam int ZW     = c2rp_pkg::Z_W;
  localparam int ID_W   = c2rp_pkg::ID_W;
  localparam int FL_W   = $bits(c2rp_pkg::c2rp_flags_t);
  localparam int SB1_W  = ID_W + P + FL_W;
  localparam int SB2_W  = ID_W + c2rp_pkg::AZ_W + FL_W;
  localparam int EXT_W  = W - P - c2rp_pkg::GUARD_BITS;
  localparam int QW     = ZW - 8;           // angle after rounding to Q7

  // whole pipe advances unless the output beat is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------- sensor registers
  logic signed [P-1:0] sensor_x_r, sensor_y_r, sensor_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_x_r <= '0;
      sensor_y_r <= '0;
      sensor_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        c2rp_pkg::CFG_SENSOR_X: sensor_x_r <= cfg_wdata;
        c2rp_pkg::CFG_SENSOR_Y: sensor_y_r <= cfg_wdata;
        c2rp_pkg::CFG_SENSOR_Z: sensor_z_r <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- offset stage
  function automatic logic signed [P-1:0] sat_diff(input logic signed [P-1:0] a,
                                                   input logic signed [P-1:0] b);
    logic signed [P:0] d;
    d = {a[P-1], a} - {b[P-1], b};
    if (d[P] != d[P-1]) begin
      sat_diff = d[P] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
    end else begin
      sat_diff = d[P-1:0];
    end
  endfunction

  logic                valid_a_r;
  logic [ID_W-1:0]     id_a_r;
  logic signed [P-1:0] dx_a_r, dy_a_r, dz_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (adv) begin
      valid_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id_a_r <= in_target_id;
      dx_a_r <= sat_diff(in_target_x, sensor_x_r);
      dy_a_r <= sat_diff(in_target_y, sensor_y_r);
      dz_a_r <= sat_diff(in_target_z, sensor_z_r);
    end
  end

  // ---------------------------------------------------------------- azimuth pass
  // Left half plane is folded by negating the vector and starting at +-180 deg.
  logic signed [W-1:0]   dx_g, dy_g, x1_in, y1_in;
  logic signed [ZW-1:0]  z1_in;
  c2rp_pkg::c2rp_flags_t flags_a;
  logic [SB1_W-1:0]      sb1_in, sb1_o;
  logic                  v1_o;
  logic signed [W-1:0]   x1_o;
  logic signed [ZW-1:0]  z1_o;

  always_comb begin
    dx_g  = {{EXT_W{dx_a_r[P-1]}}, dx_a_r, {c2rp_pkg::GUARD_BITS{1'b0}}};
    dy_g  = {{EXT_W{dy_a_r[P-1]}}, dy_a_r, {c2rp_pkg::GUARD_BITS{1'b0}}};
    x1_in = dx_a_r[P-1] ? -dx_g : dx_g;
    y1_in = dx_a_r[P-1] ? -dy_g : dy_g;
    if (!dx_a_r[P-1]) begin
      z1_in = '0;
    end else begin
      z1_in = dy_a_r[P-1] ? -c2rp_pkg::Z_HALF_TURN : c2rp_pkg::Z_HALF_TURN;
    end
    flags_a.hz_zero  = (dx_a_r == '0) && (dy_a_r == '0);
    flags_a.all_zero = flags_a.hz_zero && (dz_a_r == '0);
    sb1_in = {id_a_r, dz_a_r, flags_a};
  end

  c2rp_chain #(
    .N   (CORDIC_STAGES),
    .W   (W),
    .SBW (SB1_W)
  ) u_chain_az (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (valid_a_r),
    .in_x      (x1_in),
    .in_y      (y1_in),
    .in_z      (z1_in),
    .in_sb     (sb1_in),
    .out_valid (v1_o),
    .out_x     (x1_o),
    .out_z     (z1_o),
    .out_sb    (sb1_o)
  );

  // ---------------------------------------------------------------- horizontal range
  logic signed [ZW:0]       az_sum;
  logic signed [QW-1:0]     az_q;
  logic signed [c2rp_pkg::AZ_W-1:0] az_nxt;
  c2rp_pkg::c2rp_flags_t    flags_1;

  always_comb begin
    flags_1 = sb1_o[FL_W-1:0];
    az_sum  = {z1_o[ZW-1], z1_o} + {c2rp_pkg::ANGLE_ROUND[ZW-1], c2rp_pkg::ANGLE_ROUND};
    az_q    = az_sum[ZW:9];
    if (flags_1.hz_zero) begin
      az_nxt = '0;
    end else if (az_q > c2rp_pkg::AZ_LIMIT) begin
      az_nxt = c2rp_pkg::AZ_LIMIT;
    end else if (az_q < -c2rp_pkg::AZ_LIMIT) begin
      az_nxt = -c2rp_pkg::AZ_LIMIT;
    end else begin
      az_nxt = az_q[c2rp_pkg::AZ_W-1:0];
    end
  end

  logic [W-2:0] h_d;

  c2rp_scale #(
    .W     (W),
    .SH    (24),
    .OUT_W (W - 1)
  ) u_scale_h (
    .clk     (clk),
    .en      (adv),
    .in_mag  (x1_o),
    .out_val (h_d)
  );

  logic                             valid_c_r, valid_d_r;
  logic [ID_W-1:0]                  id_c_r, id_d_r;
  logic signed [P-1:0]              dz_c_r, dz_d_r;
  c2rp_pkg::c2rp_flags_t            flags_c_r, flags_d_r;
  logic signed [c2rp_pkg::AZ_W-1:0] az_c_r, az_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_c_r <= 1'b0;
      valid_d_r <= 1'b0;
    end else if (adv) begin
      valid_c_r <= v1_o;
      valid_d_r <= valid_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id_c_r    <= sb1_o[SB1_W-1:P+FL_W];
      dz_c_r    <= sb1_o[P+FL_W-1:FL_W];
      flags_c_r <= flags_1;
      az_c_r    <= az_nxt;
      id_d_r    <= id_c_r;
      dz_d_r    <= dz_c_r;
      flags_d_r <= flags_c_r;
      az_d_r    <= az_c_r;
    end
  end

  // ---------------------------------------------------------------- elevation pass
  logic signed [W-1:0]  x2_in, y2_in;
  logic [SB2_W-1:0]     sb2_in, sb2_o;
  logic                 v2_o;
  logic signed [W-1:0]  x2_o;
  logic signed [ZW-1:0] z2_o;

  always_comb begin
    x2_in  = {1'b0, h_d};
    y2_in  = {{EXT_W{dz_d_r[P-1]}}, dz_d_r, {c2rp_pkg::GUARD_BITS{1'b0}}};
    sb2_in = {id_d_r, az_d_r, flags_d_r};
  end

  c2rp_chain #(
    .N   (CORDIC_STAGES),
    .W   (W),
    .SBW (SB2_W)
  ) u_chain_el (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (valid_d_r),
    .in_x      (x2_in),
    .in_y      (y2_in),
    .in_z      ('0),
    .in_sb     (sb2_in),
    .out_valid (v2_o),
    .out_x     (x2_o),
    .out_z     (z2_o),
    .out_sb    (sb2_o)
  );

  // ---------------------------------------------------------------- slant range, elevation
  logic signed [ZW:0]               el_sum;
  logic signed [QW-1:0]             el_q, el_neg;
  logic signed [c2rp_pkg::EL_W-1:0] el_nxt;
  c2rp_pkg::c2rp_flags_t            flags_2;

  always_comb begin
    flags_2 = sb2_o[FL_W-1:0];
    el_sum  = {z2_o[ZW-1], z2_o} + {c2rp_pkg::ANGLE_ROUND[ZW-1], c2rp_pkg::ANGLE_ROUND};
    el_q    = el_sum[ZW:9];
    el_neg  = -el_q;
    if (flags_2.all_zero) begin
      el_nxt = '0;
    end else if (el_neg > c2rp_pkg::EL_LIMIT) begin
      el_nxt = c2rp_pkg::EL_LIMIT;
    end else if (el_neg < -c2rp_pkg::EL_LIMIT) begin
      el_nxt = -c2rp_pkg::EL_LIMIT;
    end else begin
      el_nxt = el_neg[c2rp_pkg::EL_W-1:0];
    end
  end

  c2rp_scale #(
    .W     (W),
    .SH    (32),
    .OUT_W (c2rp_pkg::RANGE_W)
  ) u_scale_r (
    .clk     (clk),
    .en      (adv),
    .in_mag  (x2_o),
    .out_val (out_range_dist)
  );

  logic                             valid_e_r, out_valid_r;
  logic [ID_W-1:0]                  id_e_r, out_echo_id_r;
  logic signed [c2rp_pkg::AZ_W-1:0] az_e_r, out_azimuth_deg_r;
  logic signed [c2rp_pkg::EL_W-1:0] el_e_r, out_elevation_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_e_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      valid_e_r   <= v2_o;
      out_valid_r <= valid_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id_e_r              <= sb2_o[SB2_W-1:c2rp_pkg::AZ_W+FL_W];
      az_e_r              <= sb2_o[c2rp_pkg::AZ_W+FL_W-1:FL_W];
      el_e_r              <= el_nxt;
      out_echo_id_r       <= id_e_r;
      out_azimuth_deg_r   <= az_e_r;
      out_elevation_deg_r <= el_e_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_echo_id       = out_echo_id_r;
  assign out_azimuth_deg   = out_azimuth_deg_r;
  assign out_elevation_deg = out_elevation_deg_r;

endmodule

/* tb/sv/cartesian_to_radar_polar_test.sv */
// cartesian_to_radar_polar_test: self-checking bench for the cartesian to radar polar converter.
// Needs c2rp_pkg and the cartesian_to_radar_polar RTL; a bit-exact CORDIC predictor lives here.
// Directed edge cases first, then random beats under bursty input and patterned output stalls.
module cartesian_to_radar_polar_test;

  localparam int CORDIC_STAGES = 20;
  localparam int POS_WIDTH     = 24;
  localparam int LATENCY       = 2 * CORDIC_STAGES + 5;
  localparam int QUIET_LIMIT   = 1000;  // cycles with no beat on either side
  localparam int RANDOM_PHASES = 6;
  localparam int BEATS_PER_PHASE = 75;

  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  // index 3 is outside the register map; writes to it must be dropped
  localparam logic [c2rp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // 1/K of the CORDIC gain, scaled by 2^24
  localparam longint UNITY_GAIN_INV = 10188014;
  localparam longint AZ_CLAMP = 23040;  // 180 deg, Q7
  localparam longint EL_CLAMP = 11520;  // 90 deg, Q7
  localparam longint RANGE_SAT = 33554431;

  // atan(2^-i) in degrees, Q16
  localparam longint ATAN_Q16 [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic [c2rp_pkg::ID_W-1:0]   id;
    logic signed [POS_WIDTH-1:0] x;
    logic signed [POS_WIDTH-1:0] y;
    logic signed [POS_WIDTH-1:0] z;
  } target_t;

  typedef struct {
    logic [c2rp_pkg::ID_W-1:0]        echo_id;
    logic [c2rp_pkg::RANGE_W-1:0]     range_dist;
    logic signed [c2rp_pkg::AZ_W-1:0] azimuth_deg;
    logic signed [c2rp_pkg::EL_W-1:0] elevation_deg;
  } polar_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT signals. Every input has a known value from time 0.
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_we    = 1'b0;
  logic [c2rp_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [POS_WIDTH-1:0]           cfg_wdata = '0;

  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic [c2rp_pkg::ID_W-1:0]   in_target_id = '0;
  logic signed [POS_WIDTH-1:0] in_target_x  = '0;
  logic signed [POS_WIDTH-1:0] in_target_y  = '0;
  logic signed [POS_WIDTH-1:0] in_target_z  = '0;

  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [c2rp_pkg::ID_W-1:0]        out_echo_id;
  logic [c2rp_pkg::RANGE_W-1:0]     out_range_dist;
  logic signed [c2rp_pkg::AZ_W-1:0] out_azimuth_deg;
  logic signed [c2rp_pkg::EL_W-1:0] out_elevation_deg;

  initial forever #6 clk = ~clk;

  cartesian_to_radar_polar #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .POS_WIDTH     (POS_WIDTH)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_target_id      (in_target_id),
    .in_target_x       (in_target_x),
    .in_target_y       (in_target_y),
    .in_target_z       (in_target_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_echo_id       (out_echo_id),
    .out_range_dist    (out_range_dist),
    .out_azimuth_deg   (out_azimuth_deg),
    .out_elevation_deg (out_elevation_deg)
  );

  // ---------------------------------------------------------------------------
  // Bench state: our copy of the sensor registers, the beats still to send and
  // the polar results the converter owes us, oldest first.
  // ---------------------------------------------------------------------------
  logic signed [POS_WIDTH-1:0] sensor_x_q = '0;
  logic signed [POS_WIDTH-1:0] sensor_y_q = '0;
  logic signed [POS_WIDTH-1:0] sensor_z_q = '0;

  target_t target_backlog [$];
  polar_t  awaited_polar  [$];

  int mismatches    = 0;
  int beats_checked = 0;
  int sensor_setups = 1;  // the reset setting counts as the first

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // target minus sensor, saturated to the position width
  function automatic longint offset_sat(logic signed [POS_WIDTH-1:0] tgt,
                                        logic signed [POS_WIDTH-1:0] sen);
    longint d;
    d = tgt;
    d = d - sen;
    return clip(d, longint'(POS_MIN), longint'(POS_MAX));
  endfunction

  // vectoring mode: drive vy to zero, accumulate the angle in vz (deg Q16)
  function automatic void cordic_vector(inout longint vx, inout longint vy, inout longint vz);
    longint sx, sy;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx += sy;
        vy -= sx;
        vz += ATAN_Q16[i];
      end else begin
        vx -= sy;
        vy += sx;
        vz -= ATAN_Q16[i];
      end
    end
  endfunction

  // magnitude times 1/K, rounded half up, dropping 'shift' bits
  function automatic longint gain_round(longint mag, int shift);
    logic [127:0] prod;
    prod = 128'((mag < 0) ? 0 : mag) * 128'(UNITY_GAIN_INV);
    prod = (prod + (128'd1 << (shift - 1))) >> shift;
    return longint'(prod[63:0]);
  endfunction

  function automatic polar_t predict_polar(target_t t);
    longint dx, dy, dz, px, py, pz, az, el, horiz, rng;
    polar_t r;
    dx = offset_sat(t.x, sensor_x_q);
    dy = offset_sat(t.y, sensor_y_q);
    dz = offset_sat(t.z, sensor_z_q);
    az = 0;
    el = 0;
    horiz = 0;
    rng = 0;
    // azimuth pass; left half plane is folded over and started at +-180 deg
    if (dx != 0 || dy != 0) begin
      if (dx < 0) begin
        px = -dx * 256;
        py = -dy * 256;
        pz = (dy >= 0 ? 180 : -180) * 65536;
      end else begin
        px = dx * 256;
        py = dy * 256;
        pz = 0;
      end
      cordic_vector(px, py, pz);
      az = clip((pz + 256) >>> 9, -AZ_CLAMP, AZ_CLAMP);
      horiz = gain_round(px, 24);
    end
    // elevation pass on (horizontal range, dz); skipped only at zero range
    if (dx != 0 || dy != 0 || dz != 0) begin
      px = horiz;
      py = dz * 256;
      pz = 0;
      cordic_vector(px, py, pz);
      el = clip(-((pz + 256) >>> 9), -EL_CLAMP, EL_CLAMP);
      rng = gain_round(px, 32);
      if (rng > RANGE_SAT) rng = RANGE_SAT;
    end
    r.echo_id       = t.id;
    r.range_dist    = rng[c2rp_pkg::RANGE_W-1:0];
    r.azimuth_deg   = az[c2rp_pkg::AZ_W-1:0];
    r.elevation_deg = el[c2rp_pkg::EL_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_target(logic [c2rp_pkg::ID_W-1:0] id,
                                     logic signed [POS_WIDTH-1:0] x,
                                     logic signed [POS_WIDTH-1:0] y,
                                     logic signed [POS_WIDTH-1:0] z);
    target_t t;
    t.id = id;
    t.x  = x;
    t.y  = y;
    t.z  = z;
    target_backlog = {target_backlog, t};
  endfunction

  // a coordinate close to the sensor; a quarter of the time exactly on it
  function automatic logic signed [POS_WIDTH-1:0] near_pos(logic signed [POS_WIDTH-1:0] base,
                                                           int span);
    int off;
    if ($urandom_range(0, 3) == 0) return base;
    off = int'($urandom_range(0, 2 * span)) - span;
    return base + off[POS_WIDTH-1:0];
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] edge_pos();
    case ($urandom_range(0, 5))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return '0;
      3:       return '1;
      4:       return POS_WIDTH'(1);
      default: return POS_WIDTH'($urandom);
    endcase
  endfunction

  function automatic target_t random_target();
    target_t t;
    int pick;
    t.id = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      t.x = POS_WIDTH'($urandom);
      t.y = POS_WIDTH'($urandom);
      t.z = POS_WIDTH'($urandom);
    end else if (pick < 70) begin
      // tiny offsets: axis-aligned, zero horizontal and zero range cases
      t.x = near_pos(sensor_x_q, 32);
      t.y = near_pos(sensor_y_q, 32);
      t.z = near_pos(sensor_z_q, 32);
    end else if (pick < 85) begin
      t.x = edge_pos();
      t.y = edge_pos();
      t.z = edge_pos();
    end else begin
      t.x = near_pos(sensor_x_q, 4096);
      t.y = near_pos(sensor_y_q, 4096);
      t.z = near_pos(sensor_z_q, 4096);
    end
    return t;
  endfunction

  // one register per clock; the spare index is hit too and must change nothing
  task automatic set_sensor(logic signed [POS_WIDTH-1:0] sx, logic signed [POS_WIDTH-1:0] sy,
                            logic signed [POS_WIDTH-1:0] sz);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= c2rp_pkg::CFG_SENSOR_X;
    cfg_wdata <= sx;
    sensor_x_q = sx;
    @(posedge clk);
    cfg_idx   <= c2rp_pkg::CFG_SENSOR_Y;
    cfg_wdata <= sy;
    sensor_y_q = sy;
    @(posedge clk);
    cfg_idx   <= c2rp_pkg::CFG_SENSOR_Z;
    cfg_wdata <= sz;
    sensor_z_q = sz;
    @(posedge clk);
    cfg_idx   <= CFG_IDX_SPARE;
    cfg_wdata <= POS_WIDTH'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sensor_setups++;
  endtask

  // every queued beat sent and every result back: the pipe is empty
  task automatic wait_drained();
    while (target_backlog.size() != 0 || in_valid || awaited_polar.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // sensor at the origin (reset value)
    add_target(32'h0000_0000, 0, 0, 0);                // zero range
    add_target(32'hFFFF_FFFF, 0, 0, 1000);             // straight up
    add_target(32'h0000_0002, 0, 0, -1000);            // straight down
    add_target(32'h0000_0003, 0, 0, POS_MAX);
    add_target(32'h0000_0004, 0, 0, POS_MIN);
    add_target(32'h0000_0005, 256, 0, 0);
    add_target(32'h0000_0006, -256, 0, 0);             // left half plane on the axis
    add_target(32'h0000_0007, -256, -1, 0);            // just below the negative x axis
    add_target(32'h0000_0008, 0, 256, 0);
    add_target(32'h0000_0009, 0, -256, 0);
    add_target(32'hA5A5_A5A5, POS_MAX, POS_MAX, POS_MAX);
    add_target(32'h5A5A_5A5A, POS_MIN, POS_MIN, POS_MIN);
    add_target(32'h8000_0000, POS_MAX, POS_MIN, 0);
    add_target(32'h7FFF_FFFF, POS_MIN, POS_MAX, 0);
    add_target(32'h0000_000E, 1, 0, 0);
    add_target(32'h0000_000F, -1, 1, -1);
    add_target(32'h0000_0010, POS_MIN, 0, POS_MAX);
    wait_drained();

    // sensor at the corners: the offsets saturate both ways
    set_sensor(POS_MAX, POS_MIN, POS_MAX);
    add_target(32'h0000_0011, POS_MIN, POS_MAX, POS_MIN);
    add_target(32'h0000_0012, POS_MAX, POS_MIN, POS_MAX);  // on the sensor
    add_target(32'h0000_0013, POS_MAX, POS_MAX, POS_MIN);
    add_target(32'h0000_0014, POS_MIN, POS_MIN, POS_MAX);
    wait_drained();

    set_sensor(POS_MIN, POS_MAX, POS_MIN);
    add_target(32'h0000_0015, POS_MAX, POS_MIN, POS_MAX);
    add_target(32'h0000_0016, POS_MIN, POS_MAX, POS_MIN);
    wait_drained();

    // random phases, each under its own sensor position
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0:       set_sensor(POS_MAX, POS_MAX, POS_MAX);
        1:       set_sensor(POS_MIN, POS_MIN, POS_MIN);
        2:       set_sensor(0, 0, 0);
        default: set_sensor(POS_WIDTH'($urandom), POS_WIDTH'($urandom), POS_WIDTH'($urandom));
      endcase
      for (int n = 0; n < BEATS_PER_PHASE; n++)
        target_backlog = {target_backlog, random_target()};
      wait_drained();
    end

    // anything arriving now is unexpected and is flagged by the checker
    repeat (LATENCY + 8) @(posedge clk);
    if (awaited_polar.size() != 0) begin
      $error("%0d polar results never arrived", awaited_polar.size());
      mismatches++;
    end

    $display("checked %0d polar beats over %0d sensor positions, incl. saturated offsets",
             beats_checked, sensor_setups);
    $display("and zero-range/vertical targets; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps. The held beat stays put while
  // stalled; its expected result is queued at the edge that accepts it.
  // ---------------------------------------------------------------------------
  target_t held_target;
  int      burst_left = 0;
  int      gap_left   = 0;

  always @(posedge clk) begin : drive_targets
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        awaited_polar = {awaited_polar, predict_polar(held_target)};
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && target_backlog.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          held_target   = target_backlog.pop_front();
          in_target_id <= held_target.id;
          in_target_x  <= held_target.x;
          in_target_y  <= held_target.y;
          in_target_z  <= held_target.z;
          nxt_valid     = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // now and then a long back-to-back run, otherwise short bursts
            burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result beat with the oldest expectation,
  // and drive out_stall as alternating runs (mostly short, sometimes long).
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  task automatic report_field(string name, longint want, longint got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_polar
    polar_t want;
    logic   nxt_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_polar.size() == 0) begin
        $error("result beat with id %h arrived with nothing expected", out_echo_id);
        mismatches++;
      end else begin
        want = awaited_polar.pop_front();
        report_field("echo_id", longint'(want.echo_id), longint'(out_echo_id));
        report_field("range_dist", longint'(want.range_dist), longint'(out_range_dist));
        report_field("azimuth_deg", longint'(want.azimuth_deg), longint'(out_azimuth_deg));
        report_field("elevation_deg", longint'(want.elevation_deg),
                     longint'(out_elevation_deg));
        beats_checked++;
      end
    end
    if (stall_left == 0) begin
      nxt_stall = ~out_stall;
      if (nxt_stall)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 4);
      else
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 12);
      out_stall <= nxt_stall;
    end else begin
      stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a beat on either channel means a hang.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no beat moved for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

endmodule
